// ----- sv/rs2pc_pkg.sv -----
// ----------------------------------------------------------------------------
// rs2pc_pkg
// Shared constants and types of the two-phase radio setting controller.
// ----------------------------------------------------------------------------
package rs2pc_pkg;

  // Packet layout
  localparam logic [3:0] IDX_DST     = 4'd0;
  localparam logic [3:0] IDX_SRC     = 4'd1;
  localparam logic [3:0] IDX_TYPE    = 4'd2;
  localparam logic [3:0] IDX_CMD     = 4'd3;
  localparam logic [3:0] IDX_VER     = 4'd4;
  localparam logic [3:0] IDX_CODE_HI = 4'd5;
  localparam logic [3:0] IDX_CODE_LO = 4'd6;
  localparam logic [3:0] IDX_POWER   = 4'd7;
  localparam logic [3:0] IDX_FACTOR  = 4'd9;
  localparam logic [3:0] IDX_DELAY   = 4'd10;
  localparam logic [3:0] IDX_FINAL   = 4'd11;
  localparam logic [3:0] PKT_LEN     = 4'd12;
  localparam logic [3:0] PKT_TOO_LONG = 4'd13;

  // Field codes
  localparam logic [7:0] TYPE_CONTROL = 8'h19;
  localparam logic [7:0] BROADCAST    = 8'hFF;
  localparam logic [7:0] VERSION      = 8'h01;
  localparam logic [7:0] CMD_PREPARE  = 8'h01;
  localparam logic [7:0] CMD_COMMIT   = 8'h02;
  localparam logic [7:0] CMD_RESTORE  = 8'h04;

  // Setting limits and reset values
  localparam logic [4:0] POWER_MIN     = 5'd8;
  localparam logic [4:0] POWER_MAX     = 5'd20;
  localparam logic [3:0] FACTOR_MIN    = 4'd7;
  localparam logic [3:0] FACTOR_MAX    = 4'd9;
  localparam logic [3:0] FACTOR_RESET  = 4'd7;
  localparam logic [4:0] DEF_POWER_RST = 5'd14;
  localparam logic [7:0] NODE_ADDR_RST = 8'd1;
  localparam logic [7:0] CTRL_ADDR_RST = 8'd3;

  // Wait timing
  localparam logic [14:0] DELAY_UNIT_MS = 15'd100;
  localparam logic [14:0] MIN_WAIT_MS   = 15'd200;

  // Configuration register indexes
  localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
  localparam logic [1:0] CFG_CTRL_ADDR = 2'd1;
  localparam logic [1:0] CFG_DEF_POWER = 2'd2;

  // Result kinds
  localparam logic ACT_ACK   = 1'b0;
  localparam logic ACT_APPLY = 1'b1;

  // Fields of a collected packet
  typedef struct packed {
    logic [7:0]  dst;
    logic [7:0]  src;
    logic [7:0]  kind;
    logic [7:0]  cmd;
    logic [7:0]  ver;
    logic [15:0] code;
    logic [7:0]  power;
    logic [7:0]  factor;
    logic [7:0]  delay;
  } pkt_t;

  // One result item
  typedef struct packed {
    logic [14:0] wait_ms;
    logic [3:0]  spreading_factor;
    logic [4:0]  tx_power_dbm;
    logic [15:0] command_code;
    logic        action;
  } result_t;

  // Configuration seen by the decision logic
  typedef struct packed {
    logic [7:0] node_addr;
    logic [7:0] ctrl_addr;
    logic [4:0] def_power;
  } cfg_t;

endpackage

// ----- sv/rs2pc_collect.sv -----
// ----------------------------------------------------------------------------
// rs2pc_collect
// Counts packet bytes and captures the fields of a control packet.
// ----------------------------------------------------------------------------
module rs2pc_collect import rs2pc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  logic [7:0] byte_i,
  input  logic last_i,
  output pkt_t pkt_o,
  output logic complete_o,
  output logic final_slot_o
);

  logic [3:0] count_q, count_d;
  pkt_t       pkt_q;

  // Advance the byte count, saturate on long packets, restart at the end
  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (last_i) begin
        count_d = '0;
      end else if (count_q < PKT_LEN) begin
        count_d = count_q + 4'd1;
      end else begin
        count_d = PKT_TOO_LONG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Capture each field at its byte position
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      case (count_q)
        IDX_DST:     pkt_q.dst         <= byte_i;
        IDX_SRC:     pkt_q.src         <= byte_i;
        IDX_TYPE:    pkt_q.kind        <= byte_i;
        IDX_CMD:     pkt_q.cmd         <= byte_i;
        IDX_VER:     pkt_q.ver         <= byte_i;
        IDX_CODE_HI: pkt_q.code[15:8]  <= byte_i;
        IDX_CODE_LO: pkt_q.code[7:0]   <= byte_i;
        IDX_POWER:   pkt_q.power       <= byte_i;
        IDX_FACTOR:  pkt_q.factor      <= byte_i;
        IDX_DELAY:   pkt_q.delay       <= byte_i;
        default: ;
      endcase
    end
  end

  // A packet of exactly twelve bytes ends on the final slot
  assign final_slot_o = (count_q == IDX_FINAL);
  assign complete_o   = accept_i && last_i && final_slot_o;
  assign pkt_o        = pkt_q;

endmodule

// ----- sv/rs2pc_decide.sv -----
// ----------------------------------------------------------------------------
// rs2pc_decide
// Checks a complete packet, keeps the pending and current settings and
// builds the result item.
// ----------------------------------------------------------------------------
module rs2pc_decide import rs2pc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    complete_i,
  input  pkt_t    pkt_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [15:0] pend_code_q, pend_code_d;
  logic [4:0]  pend_power_q, pend_power_d;
  logic [3:0]  pend_factor_q, pend_factor_d;
  logic [4:0]  cur_power_q, cur_power_d;
  logic [3:0]  cur_factor_q, cur_factor_d;

  logic        pkt_ok;
  logic        power_ok, factor_ok;
  logic [14:0] wait_raw, wait_ms;
  logic [4:0]  apply_power;
  logic [3:0]  apply_factor;
  logic        apply_ok;

  // Header and range checks of the packet
  always_comb begin
    power_ok  = pkt_i.power inside {[8'(POWER_MIN) : 8'(POWER_MAX)]};
    factor_ok = pkt_i.factor inside {[8'(FACTOR_MIN) : 8'(FACTOR_MAX)]};
    pkt_ok = (pkt_i.dst == cfg_i.node_addr || pkt_i.dst == BROADCAST) &&
             (pkt_i.src == cfg_i.ctrl_addr) &&
             (pkt_i.kind == TYPE_CONTROL) &&
             (pkt_i.ver == VERSION) &&
             (pkt_i.code != '0) && power_ok && factor_ok;
  end

  // Wait time, at least the minimum
  assign wait_raw = 15'(pkt_i.delay) * DELAY_UNIT_MS;
  assign wait_ms  = (wait_raw < MIN_WAIT_MS) ? MIN_WAIT_MS : wait_raw;

  // Command handling
  always_comb begin
    pend_code_d   = pend_code_q;
    pend_power_d  = pend_power_q;
    pend_factor_d = pend_factor_q;
    cur_power_d   = cur_power_q;
    cur_factor_d  = cur_factor_q;
    res_valid_o   = 1'b0;
    res_o.action           = ACT_ACK;
    res_o.command_code     = pkt_i.code;
    res_o.tx_power_dbm     = cur_power_q;
    res_o.spreading_factor = cur_factor_q;
    res_o.wait_ms          = '0;

    // Setting that an apply would take
    if (pkt_i.cmd == CMD_RESTORE) begin
      apply_power  = cfg_i.def_power;
      apply_factor = FACTOR_RESET;
    end else begin
      apply_power  = pend_power_q;
      apply_factor = pend_factor_q;
    end
    apply_ok = (apply_power inside {[POWER_MIN : POWER_MAX]}) &&
               (apply_factor inside {[FACTOR_MIN : FACTOR_MAX]});

    if (complete_i && pkt_ok) begin
      case (pkt_i.cmd)
        CMD_PREPARE: begin
          pend_code_d   = pkt_i.code;
          pend_power_d  = pkt_i.power[4:0];
          pend_factor_d = pkt_i.factor[3:0];
          res_valid_o   = 1'b1;
        end
        CMD_COMMIT, CMD_RESTORE: begin
          if (pkt_i.cmd == CMD_RESTORE) begin
            pend_code_d   = pkt_i.code;
            pend_power_d  = cfg_i.def_power;
            pend_factor_d = FACTOR_RESET;
          end
          if ((pkt_i.cmd == CMD_RESTORE || pend_code_q == pkt_i.code) && apply_ok) begin
            cur_power_d            = apply_power;
            cur_factor_d           = apply_factor;
            res_valid_o            = 1'b1;
            res_o.action           = ACT_APPLY;
            res_o.tx_power_dbm     = apply_power;
            res_o.spreading_factor = apply_factor;
            res_o.wait_ms          = wait_ms;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_code_q   <= '0;
      pend_power_q  <= DEF_POWER_RST;
      pend_factor_q <= FACTOR_RESET;
      cur_power_q   <= DEF_POWER_RST;
      cur_factor_q  <= FACTOR_RESET;
    end else begin
      pend_code_q   <= pend_code_d;
      pend_power_q  <= pend_power_d;
      pend_factor_q <= pend_factor_d;
      cur_power_q   <= cur_power_d;
      cur_factor_q  <= cur_factor_d;
    end
  end

endmodule

// ----- sv/radio_setting_two_phase_commit.sv -----
// ----------------------------------------------------------------------------
// radio_setting_two_phase_commit
// Two-phase radio setting control driven by received packet bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per item, tlast on the final byte of a
//   packet. Only exact twelve-byte control packets are evaluated.
//   m_axis carries one result per accepted packet: tuser 0 is a prepare
//   acknowledge with the current setting, tuser 1 an apply of a new setting.
//   cfg writes node address, controller address and default power; write
//   only while no packet is in flight.
//   Throughput: one byte per cycle while no byte is held back. The result
//   appears in the cycle after the final byte is accepted, from the output register.
//   Stall: while a result waits in the output register, bytes keep flowing;
//   only the twelfth byte of a packet is held back until the result leaves.
//   Reset: byte count cleared, pending code zero, pending and current
//   setting at 14 dBm with factor 7, registers back to their reset values.
// ----------------------------------------------------------------------------
module radio_setting_two_phase_commit import rs2pc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input: tdata = rx_byte[7:0]; tlast = end_of_packet
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  // Result output: tdata = command_code[15:0], tx_power_dbm[20:16],
  //   spreading_factor[24:21], wait_ms[39:25]; tuser = action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cfg_t    cfg_q;
  pkt_t    pkt;
  logic    accept, complete, final_slot;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_addr <= NODE_ADDR_RST;
      cfg_q.ctrl_addr <= CTRL_ADDR_RST;
      cfg_q.def_power <= DEF_POWER_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_ADDR: cfg_q.node_addr <= cfg_data_i;
        CFG_CTRL_ADDR: cfg_q.ctrl_addr <= cfg_data_i;
        CFG_DEF_POWER: cfg_q.def_power <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Hold the final byte only while a result is still waiting
  assign s_axis_tready = !(final_slot && out_valid_q && !m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  rs2pc_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .pkt_o        (pkt),
    .complete_o   (complete),
    .final_slot_o (final_slot)
  );

  rs2pc_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .complete_i  (complete),
    .pkt_i       (pkt),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {out_q.wait_ms, out_q.spreading_factor,
                          out_q.tx_power_dbm, out_q.command_code};

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(out_valid_q && !m_axis_tready))
    else $error("result overwrote a pending output");

  // Every reported power lies in the legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[20:16] >= POWER_MIN && m_axis_tdata[20:16] <= POWER_MAX))
    else $error("output power out of range");

  // An acknowledge carries no wait, an apply at least the minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[39:25] >= MIN_WAIT_MS)
                                    : (m_axis_tdata[39:25] == '0)))
    else $error("wait time does not match the result kind");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-phase radio setting controller. Packet
// bytes stream in with random bursts and gaps while the result side stalls
// on a rotating pattern. A byte-level predictor tracks the collected packet,
// the pending and current settings and the registers, and queues the
// acknowledges and applies that each accepted byte should produce.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rs2pc_pkg::*;

  typedef logic [7:0] frame_t[$];

  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam logic [7:0] CMD_NULL     = 8'h00;
  localparam logic [7:0] CMD_UNKNOWN  = 8'h03;
  localparam logic [7:0] CMD_ALL_ONES = 8'hFF;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  radio_setting_two_phase_commit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted registers and radio state
  logic [7:0]  cfg_node;
  logic [7:0]  cfg_ctrl;
  logic [4:0]  cfg_def_power;
  logic [3:0]  rx_count;
  logic [7:0]  rx_buf [12];
  logic [15:0] pend_code;
  logic [4:0]  pend_power;
  logic [3:0]  pend_factor;
  logic [4:0]  cur_power;
  logic [3:0]  cur_factor;

  result_t expected_results[$];

  int fail_count    = 0;
  int bytes_sent    = 0;
  int burst_left    = 0;
  int hold_request  = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endfunction

  function automatic void reset_prediction();
    cfg_node      = NODE_ADDR_RST;
    cfg_ctrl      = CTRL_ADDR_RST;
    cfg_def_power = DEF_POWER_RST;
    rx_count      = '0;
    pend_code     = '0;
    pend_power    = DEF_POWER_RST;
    pend_factor   = FACTOR_RESET;
    cur_power     = DEF_POWER_RST;
    cur_factor    = FACTOR_RESET;
  endfunction

  function automatic void predict_reg_write(input logic [1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_NODE_ADDR: cfg_node = val;
      CFG_CTRL_ADDR: cfg_ctrl = val;
      CFG_DEF_POWER: cfg_def_power = val[4:0];
      default: ;
    endcase
  endfunction

  // Move the pending setting to current if it is a legal radio setting
  function automatic void apply_pending(input logic [15:0] code, input logic [14:0] wait_ms);
    result_t r;
    if (pend_power < POWER_MIN || pend_power > POWER_MAX) return;
    if (pend_factor < FACTOR_MIN || pend_factor > FACTOR_MAX) return;
    cur_power          = pend_power;
    cur_factor         = pend_factor;
    r.action           = ACT_APPLY;
    r.command_code     = code;
    r.tx_power_dbm     = cur_power;
    r.spreading_factor = cur_factor;
    r.wait_ms          = wait_ms;
    expected_results.push_back(r);
  endfunction

  // Decide what a complete twelve-byte packet does
  function automatic void evaluate_packet();
    logic [15:0] code;
    logic [7:0]  pwr;
    logic [7:0]  sf;
    int          wait_val;
    result_t     r;
    code     = {rx_buf[IDX_CODE_HI], rx_buf[IDX_CODE_LO]};
    pwr      = rx_buf[IDX_POWER];
    sf       = rx_buf[IDX_FACTOR];
    wait_val = int'(rx_buf[IDX_DELAY]) * int'(DELAY_UNIT_MS);
    if (wait_val < int'(MIN_WAIT_MS)) wait_val = int'(MIN_WAIT_MS);
    if (rx_buf[IDX_DST] != cfg_node && rx_buf[IDX_DST] != BROADCAST) return;
    if (rx_buf[IDX_SRC] != cfg_ctrl || rx_buf[IDX_TYPE] != TYPE_CONTROL ||
        rx_buf[IDX_VER] != VERSION) return;
    if (code == '0 || pwr < POWER_MIN || pwr > POWER_MAX ||
        sf < FACTOR_MIN || sf > FACTOR_MAX) return;
    case (rx_buf[IDX_CMD])
      CMD_PREPARE: begin
        pend_code          = code;
        pend_power         = pwr[4:0];
        pend_factor        = sf[3:0];
        r.action           = ACT_ACK;
        r.command_code     = code;
        r.tx_power_dbm     = cur_power;
        r.spreading_factor = cur_factor;
        r.wait_ms          = '0;
        expected_results.push_back(r);
      end
      CMD_COMMIT: begin
        if (pend_code == code) apply_pending(code, wait_val[14:0]);
      end
      CMD_RESTORE: begin
        pend_code   = code;
        pend_power  = cfg_def_power;
        pend_factor = FACTOR_RESET;
        apply_pending(code, wait_val[14:0]);
      end
      default: ;
    endcase
  endfunction

  // Collect one byte; bytes past the twelfth only mark the packet as too long
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    if (rx_count < PKT_LEN) begin
      rx_buf[rx_count] = b;
      rx_count = rx_count + 4'd1;
    end else begin
      rx_count = PKT_TOO_LONG;
    end
    if (last) begin
      if (rx_count == PKT_LEN) evaluate_packet();
      rx_count = '0;
    end
  endfunction

  // Offer one byte, inserting a random gap at the start of each burst
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  function automatic frame_t make_ctrl(input logic [7:0] dst, input logic [7:0] cmd,
                                       input logic [15:0] code, input logic [7:0] pwr,
                                       input logic [7:0] sf, input logic [7:0] delay);
    frame_t f;
    f = {dst, cfg_ctrl, TYPE_CONTROL, cmd, VERSION, code[15:8], code[7:0], pwr,
         8'($urandom), sf, delay, 8'($urandom)};
    return f;
  endfunction

  // Drop valid, wait out every expected result, then let the block settle
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived",
                               expected_results.size()));
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so that writes can follow back to back
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    predict_reg_write(idx, val);
  endtask

  task automatic configure(input logic [7:0] node, input logic [7:0] ctrl,
                           input logic [7:0] def_power);
    drain();
    write_reg(CFG_NODE_ADDR, node);
    write_reg(CFG_CTRL_ADDR, ctrl);
    write_reg(CFG_DEF_POWER, def_power);
    cfg_valid_i <= 1'b0;
  endtask

  // Prepare, commit and restore flows, wait extremes and unknown commands
  task automatic test_commands();
    // commit before any prepare matches nothing
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h0001, 8'd14, 8'd7, 8'd0));
    send_frame(make_ctrl(cfg_node, CMD_PREPARE, 16'hFFFF, 8'(POWER_MAX), 8'(FACTOR_MAX), 8'd7));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'hFFFF, 8'd8, 8'd7, 8'd0));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'hFFFF, 8'd20, 8'd9, 8'd255));
    send_frame(make_ctrl(BROADCAST, CMD_PREPARE, 16'h0001, 8'(POWER_MIN), 8'(FACTOR_MIN),
                         8'd1));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h0002, 8'd8, 8'd7, 8'd2));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h0001, 8'd8, 8'd7, 8'd2));
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h8000, 8'd20, 8'd9, 8'd3));
    send_frame(make_ctrl(cfg_node, CMD_NULL, 16'h1234, 8'd12, 8'd8, 8'd4));
    send_frame(make_ctrl(cfg_node, CMD_UNKNOWN, 16'h1234, 8'd12, 8'd8, 8'd4));
    send_frame(make_ctrl(cfg_node, CMD_ALL_ONES, 16'h1234, 8'd12, 8'd8, 8'd4));
  endtask

  // Each header and range check on its own
  task automatic test_rejects();
    frame_t f;
    for (int i = 0; i < 10; i++) begin
      f = make_ctrl(cfg_node, CMD_PREPARE, 16'h5A5A, 8'd12, 8'd8, 8'd5);
      case (i)
        0: f[IDX_DST] = cfg_node + 8'd1;
        1: f[IDX_SRC] = cfg_ctrl ^ 8'h80;
        2: f[IDX_TYPE] = TYPE_CONTROL ^ 8'h01;
        3: f[IDX_VER] = VERSION + 8'd1;
        4: begin
          f[IDX_CODE_HI] = 8'h00;
          f[IDX_CODE_LO] = 8'h00;
        end
        5: f[IDX_POWER] = 8'(POWER_MIN) - 8'd1;
        6: f[IDX_POWER] = 8'(POWER_MAX) + 8'd1;
        7: f[IDX_FACTOR] = 8'(FACTOR_MIN) - 8'd1;
        8: f[IDX_FACTOR] = 8'(FACTOR_MAX) + 8'd1;
        default: f[IDX_POWER] = 8'hFF;
      endcase
      send_frame(f);
    end
    // a slipped-through prepare would make this commit apply
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h5A5A, 8'd12, 8'd8, 8'd5));
  endtask

  // Short, long and single-byte packets, and recovery after them
  task automatic test_framing();
    frame_t f;
    f = make_ctrl(cfg_node, CMD_PREPARE, 16'h0F0F, 8'd10, 8'd8, 8'd4);
    void'(f.pop_back());
    send_frame(f);
    f = make_ctrl(cfg_node, CMD_PREPARE, 16'h0F0F, 8'd10, 8'd8, 8'd4);
    f.push_back(8'h00);
    send_frame(f);
    f.delete();
    f.push_back(CMD_PREPARE);
    send_frame(f);
    f = make_ctrl(cfg_node, CMD_PREPARE, 16'h0F0F, 8'd10, 8'd8, 8'd4);
    repeat (18) f.push_back(8'($urandom));
    send_frame(f);
    // the byte count must restart after an overlong packet
    send_frame(make_ctrl(cfg_node, CMD_PREPARE, 16'h0F0F, 8'd10, 8'd8, 8'd4));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h0F0F, 8'd10, 8'd8, 8'd4));
  endtask

  // Register extremes, out-of-range default power and the spare index
  task automatic test_registers();
    configure(8'h00, 8'hFF, 8'(POWER_MIN));
    send_frame(make_ctrl(NODE_ADDR_RST, CMD_RESTORE, 16'h0100, 8'd10, 8'd8, 8'd0));
    send_frame(make_ctrl(cfg_node, CMD_PREPARE, 16'h0100, 8'd19, 8'd8, 8'd0));
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h0101, 8'd19, 8'd8, 8'd6));
    configure(BROADCAST, 8'h00, 8'(POWER_MAX));
    send_frame(make_ctrl(8'h00, CMD_PREPARE, 16'h0200, 8'd11, 8'd9, 8'd0));
    send_frame(make_ctrl(BROADCAST, CMD_RESTORE, 16'h0201, 8'd11, 8'd9, 8'd9));
    // upper data bits are dropped, leaving a default power of zero
    configure(8'h80, 8'h7F, 8'hE0);
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h2222, 8'd11, 8'd9, 8'd1));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h2222, 8'd11, 8'd9, 8'd1));
    send_frame(make_ctrl(cfg_node, CMD_PREPARE, 16'h3333, 8'd16, 8'd9, 8'd1));
    send_frame(make_ctrl(cfg_node, CMD_COMMIT, 16'h3333, 8'd16, 8'd9, 8'd40));
    configure(8'h80, 8'h7F, 8'hFF);
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h4444, 8'd16, 8'd9, 8'd1));
    drain();
    write_reg(CFG_UNUSED, 8'hFF);
    cfg_valid_i <= 1'b0;
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h4445, 8'd16, 8'd9, 8'd1));
    configure(NODE_ADDR_RST, CTRL_ADDR_RST, 8'(DEF_POWER_RST));
    send_frame(make_ctrl(cfg_node, CMD_RESTORE, 16'h4446, 8'd16, 8'd9, 8'd2));
  endtask

  // Hold the result side for a long stretch while packets keep coming
  task automatic test_backpressure();
    logic [15:0] code;
    drain();
    hold_request = 300;
    burst_left   = 200;
    for (int i = 0; i < 6; i++) begin
      code = 16'($urandom_range(1, 65535));
      send_frame(make_ctrl(cfg_node, CMD_PREPARE, code, 8'($urandom_range(8, 20)),
                           8'($urandom_range(7, 9)), 8'($urandom)));
      send_frame(make_ctrl(cfg_node, CMD_COMMIT, code, 8'd8, 8'd7, 8'($urandom)));
    end
  endtask

  // Mostly well-formed traffic with random content, plus corruption and noise
  task automatic test_random();
    int          phase_end;
    int          r;
    logic [7:0]  dst;
    logic [15:0] code;
    frame_t      f;
    for (int phase = 0; phase < 3; phase++) begin
      configure(8'($urandom), 8'($urandom),
                ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(8, 20)));
      phase_end = bytes_sent + 240;
      while (bytes_sent < phase_end) begin
        r    = $urandom_range(0, 99);
        dst  = ($urandom_range(0, 3) == 0) ? BROADCAST : cfg_node;
        code = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        f = make_ctrl(dst, CMD_PREPARE, code, 8'($urandom_range(8, 20)),
                      8'($urandom_range(7, 9)), 8'($urandom));
        if (r < 30) begin
          // keep the prepare as built
        end else if (r < 55) begin
          f[IDX_CMD] = CMD_COMMIT;
          if ($urandom_range(0, 7) != 0) begin
            f[IDX_CODE_HI] = pend_code[15:8];
            f[IDX_CODE_LO] = pend_code[7:0];
          end
        end else if (r < 65) begin
          f[IDX_CMD] = CMD_RESTORE;
        end else if (r < 70) begin
          f[IDX_CMD] = 8'($urandom);
        end else if (r < 85) begin
          f[$urandom_range(0, 11)] = 8'($urandom);
        end else begin
          f.delete();
          repeat ($urandom_range(1, 16)) f.push_back(8'($urandom));
        end
        send_frame(f);
      end
    end
  endtask

  // Result side: long hold on request, otherwise a rotating stall pattern
  initial begin : result_sink
    int          hold_left;
    int          reload;
    logic [15:0] pattern;
    hold_left = 0;
    reload    = 0;
    pattern   = '1;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (reload == 0) begin
          reload = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom);
            default: pattern = 16'($urandom) | 16'($urandom);
          endcase
        end
        reload--;
        m_axis_tready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action           = m_axis_tuser;
      got.command_code     = m_axis_tdata[15:0];
      got.tx_power_dbm     = m_axis_tdata[20:16];
      got.spreading_factor = m_axis_tdata[24:21];
      got.wait_ms          = m_axis_tdata[39:25];
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected result action=%0d code=%04h", got.action,
                                 got.command_code));
      end else begin
        want = expected_results.pop_front();
        if (got.action !== want.action || got.command_code !== want.command_code ||
            got.tx_power_dbm !== want.tx_power_dbm ||
            got.spreading_factor !== want.spreading_factor ||
            got.wait_ms !== want.wait_ms) begin
          report_failure($sformatf(
            "expected action=%0d code=%04h power=%0d factor=%0d wait=%0d, got %0d %04h %0d %0d %0d",
            want.action, want.command_code, want.tx_power_dbm, want.spreading_factor,
            want.wait_ms, got.action, got.command_code, got.tx_power_dbm,
            got.spreading_factor, got.wait_ms));
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : sequencer
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_NODE_ADDR;
    cfg_data_i    <= '0;
    reset_prediction();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands();
    test_rejects();
    test_framing();
    test_registers();
    test_backpressure();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/rs2pc_pkg.sv
sv/rs2pc_collect.sv
sv/rs2pc_decide.sv
sv/radio_setting_two_phase_commit.sv
dv/tb.sv
